// ===== rtl/core/psb_pkg.sv =====
// Shared constants for the pixel scale-by-two block: field widths,
// register addresses and reset values. No dependencies.

package psb_pkg;

  // Payload widths
  localparam int PIX_W    = 8;
  localparam int COORD_W  = 11;
  localparam int SIZE_W   = 11;
  localparam int PSUM_W   = 9;

  // Configuration port
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;
  localparam logic [PADDR_W-1:0] ADDR_MODE_DOWN = 4'h0;
  localparam logic [PADDR_W-1:0] ADDR_SRC_COLS  = 4'h4;
  localparam logic [PADDR_W-1:0] ADDR_SRC_ROWS  = 4'h8;

  // Register reset values
  localparam logic [SIZE_W-1:0] SRC_COLS_RST = 11'd640;
  localparam logic [SIZE_W-1:0] SRC_ROWS_RST = 11'd480;

  // Default size limits
  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int MAX_ROWS_DEF    = 1024;

  // Index of the last copy per source pixel when enlarging
  localparam logic [1:0] UP_LAST_K = 2'd3;

endpackage

// ===== rtl/core/psb_in_if.sv =====
// Source pixel channel: valid/ready handshake with pixel and frame start.
// Depends on psb_pkg.

interface psb_in_if;
  logic                      valid;
  logic                      ready;
  logic [psb_pkg::PIX_W-1:0] pixel_in;
  logic                      frame_start;

  modport source (output valid, output pixel_in, output frame_start, input ready);
  modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

// ===== rtl/core/psb_out_if.sv =====
// Target write channel: valid/ready handshake with target coordinates,
// pixel value and end-of-run flag. Depends on psb_pkg.

interface psb_out_if;
  logic                        valid;
  logic                        ready;
  logic [psb_pkg::COORD_W-1:0] target_row;
  logic [psb_pkg::COORD_W-1:0] target_column;
  logic [psb_pkg::PIX_W-1:0]   pixel_out;
  logic                        run_last;

  modport source (output valid, output target_row, output target_column,
                  output pixel_out, output run_last, input ready);
  modport sink   (input valid, input target_row, input target_column,
                  input pixel_out, input run_last, output ready);
endinterface

// ===== rtl/core/psb_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.

module psb_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 512
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/pixel_scale_by_two.sv =====
// Pixel scale-by-two: streaming grey image enlarge (copy) / shrink (2x2 mean).
// Depends on psb_pkg, psb_in_if, psb_out_if and psb_ram.
//
// Usage:
//   pixels  : source grey pixels in raster order; frame_start clears the row
//             and column position before its pixel.
//   writes  : target pixel writes (row, column, value); run_last marks the
//             last write caused by one source pixel.
//   APB     : mode_down (0x0), source_columns (0x4), source_rows (0x8);
//             write only while the block is idle. pready is tied high.
// Enlarge mode gives four writes per pixel through the single write port, so
// the pixel channel waits while the output stage replays them. Shrink mode
// takes one pixel per cycle unless the write channel stalls, and writes one
// mean at each odd row and odd column. A pixel's first write is registered
// in the middle stage (with the line store read), then in the output stage.
// The line store holds horizontal pair sums of the last even row; it is not
// cleared and needs no clearing pass.
// Reset clears the position counters, the pipeline valids and restores the
// register defaults. When the receiver stalls, the output stage holds its
// write, the middle stage fills, and the pixel channel drops ready.

module pixel_scale_by_two #(
  parameter int MAX_COLUMNS = psb_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = psb_pkg::MAX_ROWS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [psb_pkg::PADDR_W-1:0]  paddr,
  input  logic [psb_pkg::PDATA_W-1:0]  pwdata,
  output logic [psb_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  psb_in_if.sink                       pixels,
  psb_out_if.source                    writes
);

  localparam int CCW        = $clog2(MAX_COLUMNS);
  localparam int RCW        = $clog2(MAX_ROWS);
  localparam int LINE_DEPTH = MAX_COLUMNS / 2;
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int PW         = psb_pkg::PIX_W;
  localparam int SW         = psb_pkg::PSUM_W;
  localparam int TW         = psb_pkg::COORD_W;

  // Configuration registers
  logic                        mode_down;
  logic [psb_pkg::SIZE_W-1:0]  source_columns;
  logic [psb_pkg::SIZE_W-1:0]  source_rows;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_down      <= 1'b0;
      source_columns <= psb_pkg::SRC_COLS_RST;
      source_rows    <= psb_pkg::SRC_ROWS_RST;
    end else if (cfg_wr) begin
      unique case (paddr)
        psb_pkg::ADDR_MODE_DOWN: mode_down      <= pwdata[0];
        psb_pkg::ADDR_SRC_COLS:  source_columns <= pwdata[psb_pkg::SIZE_W-1:0];
        psb_pkg::ADDR_SRC_ROWS:  source_rows    <= pwdata[psb_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      psb_pkg::ADDR_MODE_DOWN: prdata = {{(psb_pkg::PDATA_W-1){1'b0}}, mode_down};
      psb_pkg::ADDR_SRC_COLS:  prdata = psb_pkg::PDATA_W'(source_columns);
      psb_pkg::ADDR_SRC_ROWS:  prdata = psb_pkg::PDATA_W'(source_rows);
      default:                 prdata = '0;
    endcase
  end

  // Effective frame size: zero acts as one, oversize clips to the maximum
  logic [CCW:0] cols;
  logic [RCW:0] rows;

  always_comb begin
    if (source_columns == '0) begin
      cols = (CCW+1)'(1);
    end else if (32'(source_columns) > 32'(MAX_COLUMNS)) begin
      cols = (CCW+1)'(MAX_COLUMNS);
    end else begin
      cols = (CCW+1)'(source_columns);
    end
    if (source_rows == '0) begin
      rows = (RCW+1)'(1);
    end else if (32'(source_rows) > 32'(MAX_ROWS)) begin
      rows = (RCW+1)'(MAX_ROWS);
    end else begin
      rows = (RCW+1)'(source_rows);
    end
  end

  // Position counters and left pixel of the current pair
  logic [CCW-1:0] column_count, c_start, c_cur, column_count_next;
  logic [RCW-1:0] row_count, r_start, r_cur, row_count_next;
  logic [CCW:0]   c_inc;
  logic [RCW:0]   r_inc;
  logic [PW-1:0]  left_pixel;
  logic           in_acc;

  always_comb begin
    c_start = pixels.frame_start ? '0 : column_count;
    r_start = pixels.frame_start ? '0 : row_count;
    c_cur   = ({1'b0, c_start} >= cols) ? '0 : c_start;
    r_cur   = ({1'b0, r_start} >= rows) ? '0 : r_start;
    c_inc   = {1'b0, c_cur} + (CCW+1)'(1);
    r_inc   = {1'b0, r_cur} + (RCW+1)'(1);
    column_count_next = c_inc[CCW-1:0];
    row_count_next    = r_cur;
    if (c_inc >= cols) begin
      column_count_next = '0;
      row_count_next    = (r_inc >= rows) ? '0 : r_inc[RCW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      left_pixel   <= '0;
    end else if (in_acc) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      if (mode_down && !c_cur[0]) begin
        left_pixel <= pixels.pixel_in;
      end
    end
  end

  // Line store of pair sums, addressed by pair index
  logic [31:0]   half_col, slot_full;
  logic [AW-1:0] slot;
  logic [SW-1:0] pair_sum, line_rdata;
  logic          line_we, line_re, emit;

  always_comb begin
    half_col  = 32'(c_cur) >> 1;
    slot_full = (half_col >= 32'(LINE_DEPTH)) ? half_col - 32'(LINE_DEPTH) : half_col;
    slot      = slot_full[AW-1:0];
    pair_sum  = SW'(left_pixel) + SW'(pixels.pixel_in);
    line_we   = in_acc && mode_down && c_cur[0] && !r_cur[0];
    line_re   = in_acc && mode_down && c_cur[0] && r_cur[0];
    emit      = !mode_down || (c_cur[0] && r_cur[0]);
  end

  psb_ram #(
    .WIDTH (SW),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (slot),
    .wdata (pair_sum),
    .re    (line_re),
    .raddr (slot),
    .rdata (line_rdata)
  );

  // Middle stage: waits for the line store read
  logic          s1_valid, s1_up;
  logic [TW-1:0] s1_row, s1_col;
  logic [SW-1:0] s1_val;
  logic [31:0]   row_ext, col_ext;
  logic          gen_free, s1_adv;

  // Output stage: replays one pixel up to four times
  logic          gen_valid, gen_up;
  logic [TW-1:0] gen_row, gen_col;
  logic [PW-1:0] gen_pix;
  logic [1:0]    gen_k;
  logic          gen_last, out_acc;
  logic [SW:0]   down_sum;

  assign gen_last     = !gen_up || (gen_k == psb_pkg::UP_LAST_K);
  assign out_acc      = writes.valid && writes.ready;
  assign gen_free     = !gen_valid || (out_acc && gen_last);
  assign s1_adv       = s1_valid && gen_free;
  assign pixels.ready = !s1_valid || gen_free;
  assign in_acc       = pixels.valid && pixels.ready;
  assign down_sum     = (SW+1)'(line_rdata) + (SW+1)'(s1_val);

  always_comb begin
    if (mode_down) begin
      row_ext = 32'(r_cur) >> 1;
      col_ext = 32'(c_cur) >> 1;
    end else begin
      row_ext = 32'(r_cur) << 1;
      col_ext = 32'(c_cur) << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= emit;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_up  <= !mode_down;
      s1_row <= row_ext[TW-1:0];
      s1_col <= col_ext[TW-1:0];
      s1_val <= mode_down ? pair_sum : SW'(pixels.pixel_in);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_valid <= 1'b0;
      gen_k     <= '0;
    end else if (s1_adv) begin
      gen_valid <= 1'b1;
      gen_k     <= '0;
    end else if (out_acc) begin
      if (gen_last) begin
        gen_valid <= 1'b0;
      end else begin
        gen_k <= gen_k + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      gen_up  <= s1_up;
      gen_row <= s1_row;
      gen_col <= s1_col;
      gen_pix <= s1_up ? s1_val[PW-1:0] : down_sum[SW:2];
    end
  end

  // Target coordinates: the low bit picks the copy in enlarge mode
  assign writes.valid         = gen_valid;
  assign writes.target_row    = gen_row | {{(TW-1){1'b0}}, gen_up & gen_k[1]};
  assign writes.target_column = gen_col | {{(TW-1){1'b0}}, gen_up & gen_k[0]};
  assign writes.pixel_out     = gen_pix;
  assign writes.run_last      = gen_last;

  // A run of copies continues without a gap
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    writes.valid && writes.ready && !writes.run_last |=> writes.valid)
    else $error("copy run broken before its last write");

  // Each shrink result is written only once, never replayed
  a_down_single: assert property (@(posedge clk) disable iff (rst)
    gen_valid && !gen_up |-> gen_k == 2'd0)
    else $error("shrink result repeated");

  // A stalled middle stage keeps its payload
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !gen_free |=> s1_valid && $stable(s1_val) && $stable(s1_row))
    else $error("middle stage lost its payload");

  // The line store is never read and written in one cycle
  a_line_port: assert property (@(posedge clk) disable iff (rst)
    !(line_we && line_re))
    else $error("line store read and write collide");

  // Column position stays inside the store's range
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    32'(column_count) < 32'(MAX_COLUMNS))
    else $error("column counter out of range");

endmodule

// ===== tb/pixel_scale_by_two_tb.sv =====
// Testbench for pixel_scale_by_two: drives source pixels and APB register writes, and checks
// every target write against an in-bench scaler model, with random idling on both channels.
// Depends on psb_pkg, psb_in_if, psb_out_if and the pixel_scale_by_two RTL.
`timescale 1ns / 100ps

module pixel_scale_by_two_tb;

  localparam int LINE_DEPTH   = psb_pkg::MAX_COLUMNS_DEF / 2;
  localparam int RAND_ITEMS   = 285;
  localparam int SETTLE_CYC   = 12;
  localparam int HOLD_CYC     = 150;
  localparam int RUN_LIMIT_NS = 5_000_000;

  typedef enum int {REG_MODE_DOWN, REG_SRC_COLS, REG_SRC_ROWS} reg_sel_t;
  typedef enum int {ROW_PIXEL, ROW_WRITE_REG} row_kind_t;

  typedef struct packed {
    logic [psb_pkg::COORD_W-1:0] row;
    logic [psb_pkg::COORD_W-1:0] col;
    logic [psb_pkg::PIX_W-1:0]   pix;
    logic                        last;
  } target_write_t;

  typedef struct {
    row_kind_t                   kind;
    reg_sel_t                    sel;
    logic [psb_pkg::SIZE_W-1:0]  value;
    logic [psb_pkg::PIX_W-1:0]   pix;
    logic                        fs;
    bit                          typed;
    target_write_t               first;
  } stim_row_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         psel, penable, pwrite;
  logic [psb_pkg::PADDR_W-1:0]  paddr;
  logic [psb_pkg::PDATA_W-1:0]  pwdata;
  logic [psb_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  psb_in_if  pix_if ();
  psb_out_if wr_if ();

  pixel_scale_by_two u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pixels  (pix_if),
    .writes  (wr_if)
  );

  // Model state: registers, line store of pair sums, position counters
  logic                         mode_down = 1'b0;
  logic [psb_pkg::SIZE_W-1:0]   src_cols  = psb_pkg::SRC_COLS_RST;
  logic [psb_pkg::SIZE_W-1:0]   src_rows  = psb_pkg::SRC_ROWS_RST;
  logic [psb_pkg::PSUM_W-1:0]   pair_sums    [LINE_DEPTH];
  bit                           line_written [LINE_DEPTH];
  logic [psb_pkg::PIX_W-1:0]    left_pix = '0;
  int                           col_pos = 0;
  int                           row_pos = 0;

  target_write_t       pending_writes [$];
  stim_row_t           stim_table [$];
  int                  mismatch_count = 0;

  // Channel control shared by the stimulus and the receiver
  bit                  send_calm = 1'b0;
  bit                  take_calm = 1'b0;
  int                  hold_requests = 0;
  int                  hold_seen = 0;
  bit                  cur_typed = 1'b0;
  target_write_t       cur_typed_wr = '0;

  always #5 clk = ~clk;

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

  function automatic int bound_size(input int v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic target_write_t make_write(input int row, input int col, input int pix,
                                               input bit last);
    target_write_t w;
    w.row  = row[psb_pkg::COORD_W-1:0];
    w.col  = col[psb_pkg::COORD_W-1:0];
    w.pix  = pix[psb_pkg::PIX_W-1:0];
    w.last = last;
    return w;
  endfunction

  function automatic logic [psb_pkg::SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 11'd2047;
      2: return 11'd1024;
      3: return psb_pkg::SIZE_W'($urandom_range(0, 2047));
      default: return psb_pkg::SIZE_W'($urandom_range(1, 6));
    endcase
  endfunction

  // Expected target writes for each accepted pixel request
  always @(posedge clk) begin : predict_target_writes
    int            cols_b, rows_b, r, c, slot, sum, n, pin;
    target_write_t step [4];
    if (!rst && pix_if.valid && pix_if.ready) begin
      cols_b = bound_size(int'(src_cols), psb_pkg::MAX_COLUMNS_DEF);
      rows_b = bound_size(int'(src_rows), psb_pkg::MAX_ROWS_DEF);
      pin    = int'(pix_if.pixel_in);
      if (pix_if.frame_start) begin
        col_pos = 0;
        row_pos = 0;
      end
      // size may have shrunk under the current position
      if (col_pos >= cols_b) col_pos = 0;
      if (row_pos >= rows_b) row_pos = 0;
      r = row_pos;
      c = col_pos;
      n = 0;
      if (!mode_down) begin
        step[0] = make_write(2 * r,     2 * c,     pin, 1'b0);
        step[1] = make_write(2 * r,     2 * c + 1, pin, 1'b0);
        step[2] = make_write(2 * r + 1, 2 * c,     pin, 1'b0);
        step[3] = make_write(2 * r + 1, 2 * c + 1, pin, 1'b1);
        n = 4;
      end else begin
        slot = (c / 2) % LINE_DEPTH;
        if (c % 2 == 0) begin
          left_pix = pix_if.pixel_in;
        end else if (r % 2 == 0) begin
          pair_sums[slot]    = psb_pkg::PSUM_W'(left_pix) + psb_pkg::PSUM_W'(pix_if.pixel_in);
          line_written[slot] = 1'b1;
        end else begin
          sum = int'(pair_sums[slot]) + int'(left_pix) + pin;
          step[0] = make_write(r / 2, c / 2, sum >> 2, 1'b1);
          n = 1;
        end
      end
      // hand-typed first write for directed rows
      if (cur_typed) begin
        step[0] = cur_typed_wr;
        if (n == 0) n = 1;
      end
      for (int k = 0; k < n; k++) pending_writes.push_back(step[k]);
      // advance position
      col_pos = c + 1;
      row_pos = r;
      if (col_pos >= cols_b) begin
        col_pos = 0;
        row_pos = r + 1;
        if (row_pos >= rows_b) row_pos = 0;
      end
    end
  end

  // Compare each accepted target write with the oldest pending one
  always @(posedge clk) begin : check_target_writes
    target_write_t want;
    if (!rst && wr_if.valid && wr_if.ready) begin
      if (pending_writes.size() == 0) begin
        mismatch_count++;
        $display("%0t: target write with none pending: got row %0d col %0d pix %0d last %0b",
                 $time, wr_if.target_row, wr_if.target_column, wr_if.pixel_out,
                 wr_if.run_last);
      end else begin
        want = pending_writes.pop_front();
        if (want.row !== wr_if.target_row || want.col !== wr_if.target_column ||
            want.pix !== wr_if.pixel_out || want.last !== wr_if.run_last) begin
          mismatch_count++;
          $display("%0t: target write mismatch: expected row %0d col %0d pix %0d last %0b, %s",
                   $time, want.row, want.col, want.pix, want.last,
                   $sformatf("got row %0d col %0d pix %0d last %0b", wr_if.target_row,
                             wr_if.target_column, wr_if.pixel_out, wr_if.run_last));
        end
      end
    end
  end

  // Receiver: random ready gaps per write request, plus long holds on demand
  initial begin : take_writes
    int gap;
    wr_if.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        wr_if.ready <= 1'b0;
        repeat (HOLD_CYC) @(negedge clk);
      end
      gap = take_calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        wr_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      wr_if.ready <= 1'b1;
      @(posedge clk);
      while (!(wr_if.valid && wr_if.ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_pixel(input logic [psb_pkg::PIX_W-1:0] pix, input logic fs,
                            input bit typed, input target_write_t typed_wr);
    int   gap, c, r;
    logic start_fs;
    gap = send_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    // a shrink mean must never read a line entry that no even row has written
    start_fs = fs;
    c = fs ? 0 : col_pos;
    r = fs ? 0 : row_pos;
    if (c >= bound_size(int'(src_cols), psb_pkg::MAX_COLUMNS_DEF)) c = 0;
    if (r >= bound_size(int'(src_rows), psb_pkg::MAX_ROWS_DEF)) r = 0;
    if (mode_down && (c % 2 == 1) && (r % 2 == 1) && !line_written[(c / 2) % LINE_DEPTH])
      start_fs = 1'b1;
    cur_typed    = typed;
    cur_typed_wr = typed_wr;
    pix_if.valid       <= 1'b1;
    pix_if.pixel_in    <= pix;
    pix_if.frame_start <= start_fs;
    @(posedge clk);
    while (!(pix_if.valid && pix_if.ready)) @(posedge clk);
    @(negedge clk);
  endtask

  // Sender pause: drop valid until every pending write has arrived
  task automatic drain_writes();
    pix_if.valid <= 1'b0;
    do @(negedge clk); while (pending_writes.size() != 0);
  endtask

  task automatic wait_idle();
    drain_writes();
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic cfg_write(input reg_sel_t sel, input logic [psb_pkg::SIZE_W-1:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    case (sel)
      REG_MODE_DOWN: paddr <= psb_pkg::ADDR_MODE_DOWN;
      REG_SRC_COLS:  paddr <= psb_pkg::ADDR_SRC_COLS;
      default:       paddr <= psb_pkg::ADDR_SRC_ROWS;
    endcase
    pwdata <= psb_pkg::PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (sel)
      REG_MODE_DOWN: mode_down = value[0];
      REG_SRC_COLS:  src_cols  = value;
      default:       src_rows  = value;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic add_reg(input reg_sel_t sel, input logic [psb_pkg::SIZE_W-1:0] value);
    stim_row_t row;
    row.kind  = ROW_WRITE_REG;
    row.sel   = sel;
    row.value = value;
    row.pix   = '0;
    row.fs    = 1'b0;
    row.typed = 1'b0;
    row.first = '0;
    stim_table.push_back(row);
  endtask

  task automatic add_pixel(input logic [psb_pkg::PIX_W-1:0] pix, input logic fs);
    stim_row_t row;
    row.kind  = ROW_PIXEL;
    row.sel   = REG_MODE_DOWN;
    row.value = '0;
    row.pix   = pix;
    row.fs    = fs;
    row.typed = 1'b0;
    row.first = '0;
    stim_table.push_back(row);
  endtask

  task automatic add_checked(input logic [psb_pkg::PIX_W-1:0] pix, input logic fs,
                             input target_write_t first);
    stim_row_t row;
    row.kind  = ROW_PIXEL;
    row.sel   = REG_MODE_DOWN;
    row.value = '0;
    row.pix   = pix;
    row.fs    = fs;
    row.typed = 1'b1;
    row.first = first;
    stim_table.push_back(row);
  endtask

  initial begin : stimulus
    int                          rand_items, phase, len, frame;
    logic                        mode, fs;
    logic [psb_pkg::SIZE_W-1:0]  cols, rows;
    logic [psb_pkg::PIX_W-1:0]   pix;

    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pix_if.valid = 1'b0;
    pix_if.pixel_in = '0;
    pix_if.frame_start = 1'b0;
    foreach (line_written[i]) line_written[i] = 1'b0;
    foreach (pair_sums[i]) pair_sums[i] = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset sizes in enlarge mode, frame start, extremes of the pixel
    add_checked(8'h00, 1'b0, make_write(0, 0, 'h00, 1'b0));
    add_checked(8'hFF, 1'b0, make_write(0, 2, 'hFF, 1'b0));
    add_checked(8'hA5, 1'b1, make_write(0, 0, 'hA5, 1'b0));
    add_checked(8'h5A, 1'b0, make_write(0, 2, 'h5A, 1'b0));
    // size zero acts as one: every pixel lands on the origin
    add_reg(REG_SRC_COLS, 11'd0);
    add_reg(REG_SRC_ROWS, 11'd0);
    add_checked(8'h3C, 1'b0, make_write(0, 0, 'h3C, 1'b0));
    add_checked(8'hC3, 1'b0, make_write(0, 0, 'hC3, 1'b0));
    // shrink a 2x2 frame: full-scale mean needs no clamp, then a truncated mean
    add_reg(REG_MODE_DOWN, 11'd1);
    add_reg(REG_SRC_COLS, 11'd2);
    add_reg(REG_SRC_ROWS, 11'd2);
    add_pixel(8'hFF, 1'b1);
    add_pixel(8'hFF, 1'b0);
    add_pixel(8'hFF, 1'b0);
    add_checked(8'hFF, 1'b0, make_write(0, 0, 'hFF, 1'b1));
    add_pixel(8'h01, 1'b0);
    add_pixel(8'h02, 1'b0);
    add_pixel(8'h03, 1'b0);
    add_checked(8'h05, 1'b0, make_write(0, 0, 'h02, 1'b1));
    // odd last row and column are dropped
    add_reg(REG_SRC_COLS, 11'd3);
    add_reg(REG_SRC_ROWS, 11'd3);
    for (int k = 0; k < 9; k++) add_pixel(psb_pkg::PIX_W'($urandom_range(0, 255)), k == 0);
    // largest legal size in enlarge mode
    add_reg(REG_MODE_DOWN, 11'd0);
    add_reg(REG_SRC_COLS, 11'd1024);
    add_reg(REG_SRC_ROWS, 11'd1024);
    add_checked(8'h00, 1'b1, make_write(0, 0, 'h00, 1'b0));
    add_checked(8'hFF, 1'b0, make_write(0, 2, 'hFF, 1'b0));

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_WRITE_REG)
        cfg_write(stim_table[i].sel, stim_table[i].value);
      else
        send_pixel(stim_table[i].pix, stim_table[i].fs, stim_table[i].typed,
                   stim_table[i].first);
    end

    // Random phases: mostly whole frames of random pixels, some broken by stray starts
    rand_items = 0;
    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      phase++;
      mode = (phase == 2) ? 1'b0 : 1'($urandom_range(0, 1));
      cols = pick_size();
      rows = pick_size();
      cfg_write(REG_MODE_DOWN, psb_pkg::SIZE_W'(mode));
      cfg_write(REG_SRC_COLS, cols);
      cfg_write(REG_SRC_ROWS, rows);
      send_calm = ($urandom_range(0, 3) == 0);
      take_calm = ($urandom_range(0, 3) == 0);
      frame = bound_size(int'(cols), psb_pkg::MAX_COLUMNS_DEF) *
              bound_size(int'(rows), psb_pkg::MAX_ROWS_DEF);
      len = (frame <= 48) ? frame * int'($urandom_range(1, 2)) : int'($urandom_range(16, 48));
      // back-pressure phase: receiver holds off while requests keep coming
      if (phase == 2) begin
        send_calm = 1'b1;
        len = 40;
        hold_requests++;
      end
      fs = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(0, 7))
          0: pix = 8'h00;
          1: pix = 8'hFF;
          default: pix = psb_pkg::PIX_W'($urandom_range(0, 255));
        endcase
        if (k > 0) fs = ($urandom_range(0, 29) == 0);
        send_pixel(pix, fs, 1'b0, '0);
        if ($urandom_range(0, 59) == 0) drain_writes();
        rand_items++;
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
